[rtl/ppt_pkg.sv]
`timescale 1ns / 1ps
// ppt_pkg: shared types and codes of the position and pnl tracker
// used by ppt_ctrl, ppt_datapath and position_pnl_tracker; no dependencies

package ppt_pkg;

	// item action codes
	typedef enum logic [1:0] {
		ACT_ORDER   = 2'd0,
		ACT_FILL    = 2'd1,
		ACT_HYDRATE = 2'd2
	} action_t;

	// how a fill lands on the current position
	typedef enum logic [1:0] {
		KIND_FLAT,
		KIND_INC,
		KIND_RED,
		KIND_REV
	} fill_kind_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MUL_CUR_AVG,
		MUL_QTY_PRICE,
		MUL_PNL
	} mul_sel_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic     load;
		logic     clr_step;
		logic     wr_order;
		logic     wr_hydrate;
		logic     rd_slot;
		logic     rd_pos;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     acc_add;
		logic     div_init;
		logic     div_step;
		logic     commit;
	} ppt_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic       clr_last;
		logic [1:0] action;
		logic       fill_ok;
		logic       slot_valid;
		fill_kind_t kind;
		logic       div_last;
	} ppt_status_t;

endpackage

[rtl/ppt_ctrl.sv]
`timescale 1ns / 1ps
// ppt_ctrl: sequencer of the position and pnl tracker
// depends on ppt_pkg; drives ppt_datapath through command and status structs

module ppt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ppt_pkg::ppt_status_t status,
	output ppt_pkg::ppt_cmd_t    cmd,
	output logic                 busy
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SLOT,
		ST_EVAL,
		ST_MUL2,
		ST_ACC,
		ST_DINIT,
		ST_DIV,
		ST_COMMIT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (status.action)
					ppt_pkg::ACT_ORDER: begin
						cmd.wr_order = 1'b1;
						state_d      = ST_IDLE;
					end
					ppt_pkg::ACT_HYDRATE: begin
						cmd.wr_hydrate = 1'b1;
						state_d        = ST_IDLE;
					end
					ppt_pkg::ACT_FILL: begin
						cmd.rd_slot = 1'b1;
						state_d     = ST_SLOT;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SLOT: begin
				if (status.fill_ok && status.slot_valid) begin
					cmd.rd_pos = 1'b1;
					state_d    = ST_EVAL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EVAL: begin
				unique case (status.kind)
					ppt_pkg::KIND_FLAT: state_d = ST_COMMIT;
					ppt_pkg::KIND_INC: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = ppt_pkg::MUL_CUR_AVG;
						state_d     = ST_MUL2;
					end
					ppt_pkg::KIND_RED, ppt_pkg::KIND_REV: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = ppt_pkg::MUL_PNL;
						state_d     = ST_COMMIT;
					end
				endcase
			end
			ST_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = ppt_pkg::MUL_QTY_PRICE;
				cmd.acc_load = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
		endcase
	end

	// state and registered busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

[rtl/ppt_datapath.sv]
`timescale 1ns / 1ps
// ppt_datapath: order and position memories, multiplier, divider and commit logic
// depends on ppt_pkg; sequenced by ppt_ctrl

module ppt_datapath #(
	parameter int ORDER_SLOTS  = 256,
	parameter int SYMBOL_COUNT = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppt_pkg::ppt_cmd_t    cmd,
	output ppt_pkg::ppt_status_t status,
	input  logic [1:0]           action,
	input  logic [7:0]           order_slot,
	input  logic [5:0]           symbol,
	input  logic                 side,
	input  logic                 is_filled,
	input  logic [30:0]          quantity,
	input  logic [31:0]          price,
	input  logic signed [63:0]   load_pnl,
	input  logic [31:0]          sequence_number,
	input  logic [63:0]          time_stamp,
	input  logic                 cfg_wr_en,
	input  logic [63:0]          cfg_wr_data,
	output logic [5:0]           out_symbol,
	output logic signed [31:0]   net_position,
	output logic [31:0]          entry_price,
	output logic signed [63:0]   realized,
	output logic                 drawdown_breach,
	output logic [31:0]          out_sequence,
	output logic [63:0]          out_time,
	output logic                 out_valid
);

	localparam int SLOT_AW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
	localparam int SYM_AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int CLR_N   = (ORDER_SLOTS > SYMBOL_COUNT) ? ORDER_SLOTS : SYMBOL_COUNT;
	localparam int CLR_W   = $clog2(CLR_N);
	localparam logic signed [32:0] SAT_HI = 33'sd2147483647;
	localparam logic signed [32:0] SAT_LO = -33'sd2147483647;

	typedef struct packed {
		logic       valid;
		logic       side;
		logic [5:0] sym;
	} ord_entry_t;

	typedef struct packed {
		logic signed [31:0] net;
		logic [31:0]        avg;
		logic signed [63:0] pnl;
	} pos_entry_t;

	// latched item
	logic [1:0]         act_q;
	logic [7:0]         slot_q;
	logic [5:0]         sym_q;
	logic               side_q;
	logic               filled_q;
	logic [30:0]        qty_q;
	logic [31:0]        price_q;
	logic signed [63:0] lpnl_q;
	logic [31:0]        seq_q;
	logic [63:0]        ts_q;
	logic signed [63:0] max_dd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			slot_q   <= order_slot;
			sym_q    <= symbol;
			side_q   <= side;
			filled_q <= is_filled;
			qty_q    <= quantity;
			price_q  <= price;
			lpnl_q   <= load_pnl;
			seq_q    <= sequence_number;
			ts_q     <= time_stamp;
		end
	end

	// drawdown limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dd_q <= {1'b1, 63'd0};
		end else if (cfg_wr_en) begin
			max_dd_q <= cfg_wr_data;
		end
	end

	// clear sweep counter
	logic [CLR_W-1:0] clr_cnt_q;
	logic [31:0]      clr_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign clr_ext = 32'(clr_cnt_q);

	// table indexes and range checks
	logic [31:0]        slot_ext, sym_ext, fsym_ext;
	logic [SLOT_AW-1:0] slot_idx;
	logic [SYM_AW-1:0]  sym_idx, fsym_idx;
	logic               slot_in_range, sym_in_range;
	ord_entry_t         ord_rd_q;
	pos_entry_t         pos_rd_q;

	assign slot_ext      = 32'(slot_q);
	assign sym_ext       = 32'(sym_q);
	assign fsym_ext      = 32'(ord_rd_q.sym);
	assign slot_idx      = slot_ext[SLOT_AW-1:0];
	assign sym_idx       = sym_ext[SYM_AW-1:0];
	assign fsym_idx      = fsym_ext[SYM_AW-1:0];
	assign slot_in_range = slot_ext < 32'(ORDER_SLOTS);
	assign sym_in_range  = sym_ext < 32'(SYMBOL_COUNT);

	// order table memory
	ord_entry_t order_mem [ORDER_SLOTS];

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			if (clr_ext < 32'(ORDER_SLOTS)) order_mem[clr_ext[SLOT_AW-1:0]] <= '0;
		end else if (cmd.wr_order) begin
			if (slot_in_range && sym_in_range) order_mem[slot_idx] <= {1'b1, side_q, sym_q};
		end else if (cmd.commit) begin
			order_mem[slot_idx] <= '0;
		end
		if (cmd.rd_slot) ord_rd_q <= order_mem[slot_idx];
	end

	// evaluation of the fill against the current position
	logic signed [31:0] cur, cur_neg, qty_s, q_signed;
	logic [30:0]        acur;
	logic               fill_sell, is_long;
	ppt_pkg::fill_kind_t kind;

	assign cur       = pos_rd_q.net;
	assign cur_neg   = -cur;
	assign acur      = cur[31] ? cur_neg[30:0] : cur[30:0];
	assign fill_sell = ord_rd_q.side;
	assign is_long   = !cur[31] && (cur != 32'sd0);
	assign qty_s     = {1'b0, qty_q};
	assign q_signed  = fill_sell ? -qty_s : qty_s;

	always_comb begin
		priority if (cur == 32'sd0) kind = ppt_pkg::KIND_FLAT;
		else if ((qty_q != 31'd0) && (is_long == !fill_sell)) kind = ppt_pkg::KIND_INC;
		else if (qty_q <= acur) kind = ppt_pkg::KIND_RED;
		else kind = ppt_pkg::KIND_REV;
	end

	// new position values after the fill
	pos_entry_t new_pos;
	logic       up;
	logic [31:0] diff;
	logic signed [32:0] sum33;
	logic signed [31:0] net_sat, rev_mag;
	logic signed [63:0] delta, pnl_sat;
	logic signed [64:0] sum65;
	logic [62:0] prod_q;
	logic [63:0] num_q;

	assign up      = price_q >= pos_rd_q.avg;
	assign diff    = up ? (price_q - pos_rd_q.avg) : (pos_rd_q.avg - price_q);
	assign delta   = (up == is_long) ? $signed({1'b0, prod_q}) : -$signed({1'b0, prod_q});
	assign sum65   = {pos_rd_q.pnl[63], pos_rd_q.pnl} + {delta[63], delta};
	assign sum33   = {cur[31], cur} + {q_signed[31], q_signed};
	assign rev_mag = {1'b0, qty_q} - {1'b0, acur};

	always_comb begin
		if (sum65[64] != sum65[63]) pnl_sat = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else pnl_sat = sum65[63:0];
		priority if (sum33 > SAT_HI) net_sat = SAT_HI[31:0];
		else if (sum33 < SAT_LO) net_sat = SAT_LO[31:0];
		else net_sat = sum33[31:0];
	end

	always_comb begin
		new_pos = pos_rd_q;
		unique case (kind)
			ppt_pkg::KIND_FLAT: begin
				new_pos.net = q_signed;
				new_pos.avg = price_q;
			end
			ppt_pkg::KIND_INC: begin
				new_pos.net = net_sat;
				new_pos.avg = num_q[31:0];
			end
			ppt_pkg::KIND_RED: begin
				new_pos.net = net_sat;
				new_pos.pnl = pnl_sat;
			end
			ppt_pkg::KIND_REV: begin
				new_pos.net = fill_sell ? -rev_mag : rev_mag;
				new_pos.avg = price_q;
				new_pos.pnl = pnl_sat;
			end
		endcase
	end

	// position table memory
	pos_entry_t pos_mem [SYMBOL_COUNT];

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			if (clr_ext < 32'(SYMBOL_COUNT)) pos_mem[clr_ext[SYM_AW-1:0]] <= '0;
		end else if (cmd.wr_hydrate) begin
			if (sym_in_range) pos_mem[sym_idx] <= {(side_q ? -qty_s : qty_s), price_q, lpnl_q};
		end else if (cmd.commit) begin
			pos_mem[fsym_idx] <= new_pos;
		end
		if (cmd.rd_pos) pos_rd_q <= pos_mem[fsym_idx];
	end

	// shared multiplier, registered product
	logic [30:0] mul_a;
	logic [31:0] mul_b;

	always_comb begin
		unique case (cmd.mul_sel)
			ppt_pkg::MUL_CUR_AVG: begin
				mul_a = acur;
				mul_b = pos_rd_q.avg;
			end
			ppt_pkg::MUL_QTY_PRICE: begin
				mul_a = qty_q;
				mul_b = price_q;
			end
			default: begin
				mul_a = (kind == ppt_pkg::KIND_RED) ? qty_q : acur;
				mul_b = diff;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q <= 63'(mul_a) * 63'(mul_b);
	end

	// weighted average numerator and restoring divider, one quotient bit a cycle
	logic [32:0] total, rem_q;
	logic [33:0] rem_sh;
	logic        q_bit;
	logic [4:0]  div_cnt_q;

	assign total  = 33'(acur) + 33'(qty_q);
	assign rem_sh = {rem_q, num_q[31]};
	assign q_bit  = rem_sh >= {1'b0, total};

	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			num_q <= {1'b0, prod_q};
		end else if (cmd.acc_add) begin
			num_q <= num_q + {1'b0, prod_q};
		end else if (cmd.div_step) begin
			num_q[31:0] <= {num_q[30:0], q_bit};
		end
		if (cmd.div_init) begin
			rem_q     <= {1'b0, num_q[63:32]};
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= q_bit ? 33'(rem_sh - {1'b0, total}) : rem_sh[32:0];
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// result registers
	logic out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_symbol      <= ord_rd_q.sym;
			net_position    <= new_pos.net;
			entry_price     <= new_pos.avg;
			realized        <= new_pos.pnl;
			drawdown_breach <= new_pos.pnl < max_dd_q;
			out_sequence    <= seq_q;
			out_time        <= ts_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.commit;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	assign status.clr_last   = clr_cnt_q == CLR_W'(CLR_N - 1);
	assign status.action     = act_q;
	assign status.fill_ok    = filled_q && slot_in_range;
	assign status.slot_valid = ord_rd_q.valid;
	assign status.kind       = kind;
	assign status.div_last   = div_cnt_q == 5'd31;

endmodule

[rtl/position_pnl_tracker.sv]
`timescale 1ns / 1ps
// position_pnl_tracker: top level of the average-cost position and pnl tracker
// depends on ppt_pkg, ppt_ctrl and ppt_datapath
//
// Usage:
// - command channel: an item is taken when start is high and busy is low;
//   action 0 records an order slot, 1 applies an execution report,
//   2 loads a position for one symbol
// - result channel: out_valid is high for one cycle with the updated position;
//   the receiver cannot stall it, so results must be taken when shown
// - config: cfg_wr_en writes cfg_wr_data into the drawdown limit at once
// - order and hydrate items finish in the decode state; a report that finds no valid
//   slot ends in the slot state; a fill from flat or a reducing/reversing fill goes
//   from evaluation straight to commit
// - a fill in the same direction adds two multiplies for the weighted sum and a
//   32-step restoring divider for the average price before commit
// - after reset busy stays high while both tables are swept to zero; config
//   writes are taken meanwhile

module position_pnl_tracker #(
	parameter int ORDER_SLOTS  = 256,
	parameter int SYMBOL_COUNT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [7:0]         order_slot,
	input  logic [5:0]         symbol,
	input  logic               side,
	input  logic               is_filled,
	input  logic [30:0]        quantity,
	input  logic [31:0]        price,
	input  logic signed [63:0] load_pnl,
	input  logic [31:0]        sequence_number,
	input  logic [63:0]        time_stamp,
	input  logic               cfg_wr_en,
	input  logic [63:0]        cfg_wr_data,
	output logic               out_valid,
	output logic [5:0]         out_symbol,
	output logic signed [31:0] net_position,
	output logic [31:0]        entry_price,
	output logic signed [63:0] realized,
	output logic               drawdown_breach,
	output logic [31:0]        out_sequence,
	output logic [63:0]        out_time
);

	ppt_pkg::ppt_cmd_t    cmd;
	ppt_pkg::ppt_status_t status;

	// sequencer
	ppt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// tables and arithmetic
	ppt_datapath #(
		.ORDER_SLOTS  (ORDER_SLOTS),
		.SYMBOL_COUNT (SYMBOL_COUNT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.action          (action),
		.order_slot      (order_slot),
		.symbol          (symbol),
		.side            (side),
		.is_filled       (is_filled),
		.quantity        (quantity),
		.price           (price),
		.load_pnl        (load_pnl),
		.sequence_number (sequence_number),
		.time_stamp      (time_stamp),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.out_symbol      (out_symbol),
		.net_position    (net_position),
		.entry_price     (entry_price),
		.realized        (realized),
		.drawdown_breach (drawdown_breach),
		.out_sequence    (out_sequence),
		.out_time        (out_time),
		.out_valid       (out_valid)
	);

	// a result only follows a cycle of work on an item
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(busy))
		else $error("result without a preceding busy cycle");

	// never two results back to back
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |=> !out_valid)
		else $error("result strobe held for two cycles");

	// net position stays within the saturated range
	a_net_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (net_position != 32'sh8000_0000))
		else $error("net position outside saturation range");

endmodule

[verif/position_pnl_tracker_test.sv]
`timescale 1ns / 1ps
// position_pnl_tracker_test: self-checking bench for the position and pnl tracker
// depends on ppt_pkg and position_pnl_tracker; predicts each fill result on its own

module position_pnl_tracker_test;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam longint PNL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint PNL_MIN = 64'sh8000_0000_0000_0000;
	localparam longint QTY_LIMIT = 64'sd2147483647;

	typedef struct {
		logic [1:0]  act;
		logic [7:0]  slot;
		logic [5:0]  sym;
		logic        sell;
		logic        filled;
		logic [30:0] qty;
		logic [31:0] px;
		logic [63:0] pnl;
		logic [31:0] seq;
		logic [63:0] stamp;
	} cmd_t;

	typedef struct {
		logic [5:0]  sym;
		logic [31:0] net;
		logic [31:0] avg;
		logic [63:0] pnl;
		logic        breach;
		logic [31:0] seq;
		logic [63:0] stamp;
	} position_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] action = 0;
	logic [7:0] order_slot = 0;
	logic [5:0] symbol = 0;
	logic side = 0;
	logic is_filled = 0;
	logic [30:0] quantity = 0;
	logic [31:0] price = 0;
	logic signed [63:0] load_pnl = 0;
	logic [31:0] sequence_number = 0;
	logic [63:0] time_stamp = 0;
	logic cfg_wr_en = 0;
	logic [63:0] cfg_wr_data = 0;
	logic out_valid;
	logic [5:0] out_symbol;
	logic signed [31:0] net_position;
	logic [31:0] entry_price;
	logic signed [63:0] realized;
	logic drawdown_breach;
	logic [31:0] out_sequence;
	logic [63:0] out_time;

	cmd_t cmd_queue[$];
	position_t position_queue[$];
	int errors = 0;
	bit taken = 0;

	// predictor state
	bit          slot_live[256];
	logic [5:0]  slot_sym[256];
	bit          slot_sell[256];
	longint      book_qty[64];
	logic [31:0] book_avg[64];
	longint      book_pnl[64];
	longint      dd_limit = PNL_MIN;

	position_pnl_tracker uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .order_slot(order_slot), .symbol(symbol), .side(side),
		.is_filled(is_filled), .quantity(quantity), .price(price),
		.load_pnl(load_pnl), .sequence_number(sequence_number),
		.time_stamp(time_stamp), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid), .out_symbol(out_symbol),
		.net_position(net_position), .entry_price(entry_price), .realized(realized),
		.drawdown_breach(drawdown_breach), .out_sequence(out_sequence),
		.out_time(out_time)
	);

	always #10 clk = ~clk;

	initial begin
		#20ms;
		$display("position_pnl_tracker: mismatch");
		$finish;
	end

	function automatic longint add_sat(longint a, longint d);
		logic signed [64:0] s;
		s = 65'(a) + 65'(d);
		if (s[64] != s[63]) return s[64] ? PNL_MIN : PNL_MAX;
		return longint'(s[63:0]);
	endfunction

	// pnl of closing mag lots at px against avg
	function automatic longint close_gain(longint unsigned mag, logic [31:0] px,
			logic [31:0] avg, bit long_pos);
		bit up;
		longint unsigned diff;
		longint m;
		up = px >= avg;
		diff = up ? 64'(px - avg) : 64'(avg - px);
		m = longint'(mag * diff);
		return (up == long_pos) ? m : -m;
	endfunction

	// apply one transfer to the predictor, queueing the position it reports
	task automatic predict_position(cmd_t c);
		int s;
		bit sell;
		longint cur;
		longint unsigned acur, q, num, total;
		logic [31:0] avg;
		longint pnl;
		position_t r;
		if (c.act == ppt_pkg::ACT_ORDER) begin
			slot_live[c.slot] = 1;
			slot_sym[c.slot] = c.sym;
			slot_sell[c.slot] = c.sell;
			return;
		end
		if (c.act == ppt_pkg::ACT_HYDRATE) begin
			book_qty[c.sym] = c.sell ? -longint'(c.qty) : longint'(c.qty);
			book_avg[c.sym] = c.px;
			book_pnl[c.sym] = longint'(c.pnl);
			return;
		end
		if (c.act != ppt_pkg::ACT_FILL || !c.filled || !slot_live[c.slot]) return;
		s = slot_sym[c.slot];
		sell = slot_sell[c.slot];
		cur = book_qty[s];
		avg = book_avg[s];
		pnl = book_pnl[s];
		q = 64'(c.qty);
		acur = cur < 0 ? longint'(-cur) : longint'(cur);
		if (cur == 0) begin
			cur = sell ? -longint'(q) : longint'(q);
			avg = c.px;
		end else if (q != 0 && ((cur > 0) == !sell)) begin
			total = acur + q;
			num = acur * 64'(avg) + q * 64'(c.px);
			avg = 32'(num / total);
			cur = sell ? cur - longint'(q) : cur + longint'(q);
			if (cur > QTY_LIMIT) cur = QTY_LIMIT;
			if (cur < -QTY_LIMIT) cur = -QTY_LIMIT;
		end else if (q <= acur) begin
			pnl = add_sat(pnl, close_gain(q, c.px, avg, cur > 0));
			cur = sell ? cur - longint'(q) : cur + longint'(q);
		end else begin
			pnl = add_sat(pnl, close_gain(acur, c.px, avg, cur > 0));
			cur = sell ? -longint'(q - acur) : longint'(q - acur);
			avg = c.px;
		end
		book_qty[s] = cur;
		book_avg[s] = avg;
		book_pnl[s] = pnl;
		slot_live[c.slot] = 0;
		r.sym = 6'(s);
		r.net = 32'(cur);
		r.avg = avg;
		r.pnl = pnl;
		r.breach = pnl < dd_limit;
		r.seq = c.seq;
		r.stamp = c.stamp;
		position_queue.insert(position_queue.size(), r);
	endtask

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] got);
		if (exp !== got) begin
			$display("%0t %s expected %h actual %h", $realtime, name, exp, got);
			errors++;
		end
	endfunction

	// monitor: compare results, then predict from an accepted transfer
	always @(posedge clk) begin
		position_t e;
		cmd_t c;
		if (arst_n) begin
			if (out_valid) begin
				if (position_queue.size() == 0) begin
					$display("%0t unexpected result for symbol %0d", $realtime, out_symbol);
					errors++;
				end else begin
					e = position_queue.pop_front();
					check_field("out_symbol", 64'(e.sym), 64'(out_symbol));
					check_field("net_position", 64'(e.net), {32'd0, net_position});
					check_field("entry_price", 64'(e.avg), 64'(entry_price));
					check_field("realized", e.pnl, realized);
					check_field("drawdown_breach", 64'(e.breach), 64'(drawdown_breach));
					check_field("out_sequence", 64'(e.seq), 64'(out_sequence));
					check_field("out_time", e.stamp, out_time);
				end
			end
			if (cfg_wr_en) dd_limit = longint'(cfg_wr_data);
			if (start && !busy) begin
				c.act = action; c.slot = order_slot; c.sym = symbol; c.sell = side;
				c.filled = is_filled; c.qty = quantity; c.px = price; c.pnl = load_pnl;
				c.seq = sequence_number; c.stamp = time_stamp;
				predict_position(c);
				taken = 1;
			end
		end
	end

	// driver: bursts of transfers separated by random gaps
	int gap_left = 0;
	int burst_left = 0;
	always @(negedge clk) begin
		cmd_t c;
		bit next_start;
		next_start = start && !taken;
		taken = 0;
		if (!next_start && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_queue.size() > 0) begin
				c = cmd_queue.pop_front();
				action <= c.act; order_slot <= c.slot; symbol <= c.sym; side <= c.sell;
				is_filled <= c.filled; quantity <= c.qty; price <= c.px;
				load_pnl <= c.pnl; sequence_number <= c.seq; time_stamp <= c.stamp;
				next_start = 1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
					gap_left = $urandom_range(1, 8);
				end
			end
		end
		start <= next_start;
	end

	task automatic add_cmd(logic [1:0] act, logic [7:0] slot, logic [5:0] sym, logic sell,
			logic filled, logic [30:0] qty, logic [31:0] px, logic [63:0] pnl);
		cmd_t c;
		c.act = act; c.slot = slot; c.sym = sym; c.sell = sell; c.filled = filled;
		c.qty = qty; c.px = px; c.pnl = pnl;
		c.seq = $urandom;
		c.stamp = {$urandom, $urandom};
		cmd_queue.insert(cmd_queue.size(), c);
	endtask

	function automatic logic [30:0] pick_qty();
		case ($urandom_range(0, 9))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2, 3, 4, 5, 6: return 31'($urandom_range(1, 1000));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_price();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2, 3, 4: return 32'h0064_0000 + 32'($urandom_range(0, 32'h0010_0000));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick_pnl();
		case ($urandom_range(0, 5))
			0: return PNL_MIN + 64'($urandom_range(0, 1000));
			1: return PNL_MAX - 64'($urandom_range(0, 1000));
			2: return 64'd0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_traffic(int count);
		int n;
		logic [7:0] slot;
		logic [5:0] sym;
		int r;
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			slot = 8'($urandom);
			sym = $urandom_range(0, 4) == 0 ? 6'($urandom) : 6'($urandom_range(0, 5));
			if (r < 60) begin
				// well-formed order then fill, sometimes a stale second report
				add_cmd(ppt_pkg::ACT_ORDER, slot, sym, 1'($urandom), 1'($urandom),
					31'($urandom), $urandom, {$urandom, $urandom});
				add_cmd(ppt_pkg::ACT_FILL, slot, 6'($urandom), 1'($urandom), 1'b1,
					pick_qty(), pick_price(), {$urandom, $urandom});
				n += 2;
				if ($urandom_range(0, 9) == 0) begin
					add_cmd(ppt_pkg::ACT_FILL, slot, 6'($urandom), 1'($urandom), 1'b1,
						pick_qty(), pick_price(), {$urandom, $urandom});
					n++;
				end
			end else if (r < 70) begin
				add_cmd(ppt_pkg::ACT_HYDRATE, 8'($urandom), sym, 1'($urandom),
					1'($urandom), pick_qty(), pick_price(), pick_pnl());
				n++;
			end else if (r < 82) begin
				add_cmd(ppt_pkg::ACT_FILL, slot, 6'($urandom), 1'($urandom),
					1'($urandom), pick_qty(), pick_price(), {$urandom, $urandom});
				n++;
			end else if (r < 92) begin
				add_cmd(ppt_pkg::ACT_ORDER, slot, sym, 1'($urandom), 1'($urandom),
					pick_qty(), $urandom, {$urandom, $urandom});
				n++;
			end else begin
				add_cmd(ACT_UNUSED, slot, sym, 1'($urandom), 1'($urandom), pick_qty(),
					$urandom, {$urandom, $urandom});
				n++;
			end
		end
	endtask

	// wait for all transfers and results, then let a non-result item finish
	task automatic drain();
		while (cmd_queue.size() > 0 || start || position_queue.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_limit(logic [63:0] v);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	// stimulus: directed cases, then random phases under several limits
	initial begin
		logic [63:0] limits[4];
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// open from flat at the extremes, then grow into quantity saturation
		add_cmd(ppt_pkg::ACT_ORDER, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 0, 0, 0, 1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		add_cmd(ppt_pkg::ACT_ORDER, 255, 0, 0, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 255, 0, 0, 1, 31'h7FFF_FFFF, 0, 0);
		// reduce, zero quantity on an open position, then reverse
		add_cmd(ppt_pkg::ACT_ORDER, 1, 0, 1, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 1, 0, 0, 1, 1000, 32'h0001_0000, 0);
		add_cmd(ppt_pkg::ACT_ORDER, 2, 0, 1, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 2, 0, 0, 1, 0, 32'h0002_0000, 0);
		add_cmd(ppt_pkg::ACT_ORDER, 3, 0, 1, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 3, 0, 0, 1, 31'h7FFF_FFFF, 32'h8000_0000, 0);
		// rejected report keeps the slot, report on a free slot, unused code
		add_cmd(ppt_pkg::ACT_ORDER, 4, 1, 1, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 4, 0, 0, 0, 50, 32'h0003_0000, 0);
		add_cmd(ppt_pkg::ACT_FILL, 200, 0, 0, 1, 50, 32'h0003_0000, 0);
		add_cmd(ACT_UNUSED, 4, 1, 0, 1, 50, 32'h0003_0000, 0);
		// overwritten order entry, then the fill uses the new side and symbol
		add_cmd(ppt_pkg::ACT_ORDER, 4, 2, 0, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 4, 0, 0, 1, 77, 32'h0004_0000, 0);
		// pnl saturation low and high from hydrated positions
		add_cmd(ppt_pkg::ACT_HYDRATE, 0, 63, 0, 0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, PNL_MIN);
		add_cmd(ppt_pkg::ACT_ORDER, 5, 63, 1, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 5, 0, 0, 1, 31'h7FFF_FFFF, 0, 0);
		add_cmd(ppt_pkg::ACT_HYDRATE, 0, 62, 1, 0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, PNL_MAX);
		add_cmd(ppt_pkg::ACT_ORDER, 6, 62, 0, 0, 0, 0, 0);
		add_cmd(ppt_pkg::ACT_FILL, 6, 0, 0, 1, 31'h7FFF_FFFF, 0, 0);
		drain();

		limits[0] = PNL_MAX;
		limits[1] = 0;
		limits[2] = PNL_MIN;
		limits[3] = {$urandom, $urandom};
		foreach (limits[i]) begin
			write_limit(limits[i]);
			random_traffic(460);
			drain();
		end

		if (errors == 0)
			$display("position_pnl_tracker: match");
		else
			$display("position_pnl_tracker: mismatch");
		$finish;
	end

endmodule

[filelist.f]
rtl/ppt_pkg.sv
rtl/ppt_ctrl.sv
rtl/ppt_datapath.sv
rtl/position_pnl_tracker.sv
verif/position_pnl_tracker_test.sv
